FILE: rtl/insr_pkg.sv
`timescale 1ns / 1ps

package insr_pkg;

    localparam int LIST_DEPTH  = 32;
    localparam int VALUE_WIDTH = 32;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // Control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic insert;     // place the incoming value into the chain
        logic shift_out;  // move every entry one cell toward the head
    } cell_ctrl_t;

endpackage

FILE: rtl/insr_cell.sv
`timescale 1ns / 1ps

module insr_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  insr_pkg::cell_ctrl_t ctrl,
    input  insr_pkg::value_t    new_value,
    input  insr_pkg::value_t    prev_value,
    input  logic                prev_ge,
    input  logic                prev_open,
    input  insr_pkg::value_t    next_value,
    input  logic                next_valid,
    output insr_pkg::value_t    value,
    output logic                valid,
    output logic                ge,
    output logic                open
);
    import insr_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;

    // The entry is greater than or equal to the new value, so the new value goes in front.
    assign ge   = valid_reg && (value_reg >= new_value);
    assign open = ge || !valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift_out) begin
            value_next = next_value;
            valid_next = next_valid;
        end else if (ctrl.insert) begin
            if (prev_ge) begin
                value_next = prev_value;
                valid_next = 1'b1;
            end else if (open && !prev_open) begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

FILE: rtl/insertion_sorter_core.sv
`timescale 1ns / 1ps
// Insertion: one item per cycle while s_ready is high; every cell compares and shifts
// in the same cycle. Drain: the item marked last is inserted unless the list is full,
// and in the next cycle the sorted list begins to leave from the head cell, one item
// per cycle while m_ready is high. The input is not ready during the drain, so a new
// set cannot enter until the previous set has left.
// Reset (aresetn low at a clock edge, synchronous) empties the chain and clears overflow.

module insertion_sorter_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  insr_pkg::value_t s_value,
    input  logic             s_final_item,
    input  logic             s_valid,
    output logic             s_ready,
    output insr_pkg::value_t m_sorted_value,
    output logic             m_end_of_run,
    output logic             m_overflow,
    output logic             m_valid,
    input  logic             m_ready
);
    import insr_pkg::*;

    // The list is held in a row of cells. Cell 0 holds the smallest entry, and the
    // occupied cells always form a prefix of the row. A new item is broadcast to all
    // cells: each valid cell flags whether its entry is greater than or equal to the
    // item. Cells after the first flagged one take the entry of their left
    // neighbor, and the first flagged (or first empty) cell takes the new item.
    // During the drain the whole row shifts toward cell 0, which serves as the
    // output register.

    value_t                 cell_value [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]  cell_valid;
    logic [LIST_DEPTH-1:0]  cell_ge;
    logic [LIST_DEPTH-1:0]  cell_open;
    cell_ctrl_t             ctrl;

    logic draining_reg;
    logic draining_next;
    logic dropped_reg;
    logic dropped_next;

    logic in_fire;
    logic out_fire;
    logic list_full;

    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign list_full = cell_valid[LIST_DEPTH-1];

    // A full list drops the item; only the overflow flag records it.
    assign ctrl.insert    = in_fire && !list_full;
    assign ctrl.shift_out = out_fire;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        value_t prev_value;
        logic   prev_ge;
        logic   prev_open;
        value_t next_value;
        logic   next_valid;

        if (i == 0) begin : g_head
            // The head has no left neighbor: it takes the new item whenever it is open.
            assign prev_value = s_value;
            assign prev_ge    = 1'b0;
            assign prev_open  = 1'b0;
        end else begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_ge    = cell_ge[i-1];
            assign prev_open  = cell_open[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_tail
            // The tail empties during the drain.
            assign next_value = s_value;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        insr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_value  (s_value),
            .prev_value (prev_value),
            .prev_ge    (prev_ge),
            .prev_open  (prev_open),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .ge         (cell_ge[i]),
            .open       (cell_open[i])
        );
    end

    // The drain starts after the last item of a set and ends when the item flagged
    // as end of run is taken; the overflow flag is cleared with it.
    always_comb begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        if (in_fire && list_full) begin
            dropped_next = 1'b1;
        end
        if (in_fire && s_final_item) begin
            draining_next = 1'b1;
        end
        if (out_fire && m_end_of_run) begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end else begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign s_ready        = !draining_reg;
    assign m_valid        = draining_reg && cell_valid[0];
    assign m_sorted_value = cell_value[0];
    // The head holds the last entry of the set when no entry stands behind it.
    assign m_end_of_run   = !cell_valid[1];
    assign m_overflow     = dropped_reg;

endmodule

FILE: rtl/insr_checker.sv
`timescale 1ns / 1ps

module insr_checker (
    input logic             aclk,
    input logic             aresetn,
    input insr_pkg::value_t s_value,
    input logic             s_final_item,
    input logic             s_valid,
    input logic             s_ready,
    input insr_pkg::value_t m_sorted_value,
    input logic             m_end_of_run,
    input logic             m_overflow,
    input logic             m_valid,
    input logic             m_ready
);
    import insr_pkg::*;

    // No new item is taken while sorted items are leaving.
    a_no_input_during_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while results are pending");

    // The last item of a set closes the input and starts the drain.
    a_final_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_item) |=> (!s_ready && m_valid))
        else $error("drain did not start after the last item");

    // Nothing follows the end-of-run item, and the input reopens.
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_run) |=> (!m_valid && s_ready))
        else $error("results continue after end of run");

    // The overflow flag is the same on every item of one run.
    a_overflow_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_end_of_run) |=> (m_valid && $stable(m_overflow)))
        else $error("overflow changed within a run");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sorted_value)))
        else $error("stalled result changed");

endmodule

bind insertion_sorter_core insr_checker u_insr_checker (.*);
